@@ rtl/pfba_pkg.sv @@
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 28;
  localparam int KIB_W      = 19;
  localparam int RSV_W      = 17;
  localparam int CFG_DATA_W = 19;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_W     = 8;

  localparam logic [KIB_W-1:0] USABLE_KIB_RST = 19'd262144;
  localparam logic [RSV_W-1:0] RESERVED_RST   = 17'd1024;
  localparam logic [WORD_W-1:0] WORD_FULL     = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_USABLE_KIB = 1'b0,
    CFG_RESERVED   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/pfba_if.sv @@
// Valid/ready channel interfaces for request and result transactions.
interface pfba_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfba_pkg::MODE_W-1:0]   mode;
  logic [pfba_pkg::ADDR_W-1:0]   phys_addr;

  modport source (output valid, output mode, output phys_addr, input ready);
  modport sink   (input valid, input mode, input phys_addr, output ready);
endinterface

interface pfba_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfba_pkg::ADDR_W-1:0]   frame_addr;
  logic                          none_free;

  modport source (output valid, output frame_addr, output none_free, input ready);
  modport sink   (input valid, input frame_addr, input none_free, output ready);
endinterface

@@ rtl/pfba_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/page_frame_bitmap_allocator_unit.sv @@
// Page frame bitmap allocator: one used bit per frame, kept in an 8-bit-wide RAM.
//
// Requests arrive on in_if (mode, phys_addr); every request gives exactly one
// result transaction on out_if (frame_addr, none_free). cfg_* writes the
// installed memory size (index 0) and the reserved frame count (index 1).
// One request is worked on at a time; the bitmap RAM (MAP_WORDS = MAX_PAGES/8
// words, rounded up, one read and one write per cycle) is walked as below:
//   init     : every map word rewritten, one map word per cycle
//   allocate : scan up from word 0 to the lowest word with a free bit;
//              the whole map is scanned when no frame is free
//   free     : read, modify-write, result
//   mode 3   : result only, map untouched
// After reset the block sweeps the whole map to all-used (MAP_WORDS words,
// 8192 at the default size), with in_if.ready low; cfg writes are taken.
// A finished result sits in an output register: the next request is accepted
// while out_if is stalled, and its result waits until that register drains.
module page_frame_bitmap_allocator_unit #(
  parameter int MAX_PAGES = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfba_in_if.sink                        in_if,
  pfba_out_if.source                     out_if,
  input  logic                           cfg_wen,
  input  logic [0:0]                     cfg_addr,
  input  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfba_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + 7) / 8;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = AW + 1;
  localparam int FRAME_W   = ADDR_W - PAGE_SHIFT;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  function automatic logic [2:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  state_t              state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       chk_addr_r, chk_addr_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [ADDR_W-1:0]   res_frame_r, res_frame_nxt;
  logic                res_none_r, res_none_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_frame_r;
  logic                out_none_r;
  logic [KIB_W-1:0]    usable_kib_r;
  logic [RSV_W-1:0]    reserved_r;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                accept, out_load;
  mode_t               in_mode;
  logic [FRAME_W-1:0]  free_frame;
  logic                free_in_range;
  logic [31:0]         lim_frames, rsv_frames;
  logic [CNT_W-1:0]    lim_words, rsv_words;
  logic [CNT_W-1:0]    addr_ext;
  logic [WORD_W-1:0]   init_word;
  logic                word_full;
  logic [2:0]          zero_bit;
  logic [AW+PAGE_SHIFT+2:0] hit_byte_addr;

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready       = (state_r == ST_IDLE);
  assign accept            = in_if.valid && in_if.ready;
  assign in_mode           = mode_t'(in_if.mode);
  assign out_load          = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);

  assign out_if.valid      = out_valid_r;
  assign out_if.frame_addr = out_frame_r;
  assign out_if.none_free  = out_none_r;

  // Frame numbers and range check for a free request
  assign free_frame    = in_if.phys_addr[ADDR_W-1:PAGE_SHIFT];
  assign free_in_range = (32'(free_frame) < 32'(MAX_PAGES));

  // Init limits: usable frames = kib/4, saturated, then in whole words
  assign lim_frames = (32'(usable_kib_r >> 2) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                                : 32'(usable_kib_r >> 2);
  assign rsv_frames = (32'(reserved_r) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                         : 32'(reserved_r);
  assign lim_words  = CNT_W'(lim_frames >> 3);
  assign rsv_words  = CNT_W'(rsv_frames >> 3);
  assign addr_ext   = {1'b0, addr_r};

  always_comb begin
    if (addr_ext >= lim_words) begin
      init_word = WORD_FULL;
    end else if (addr_ext < rsv_words) begin
      init_word = WORD_FULL;
    end else if (addr_ext == rsv_words) begin
      init_word = WORD_W'((9'd1 << rsv_frames[2:0]) - 9'd1);
    end else begin
      init_word = '0;
    end
  end

  assign word_full     = (ram_rdata == WORD_FULL);
  assign zero_bit      = lowest_zero(ram_rdata);
  assign hit_byte_addr = {chk_addr_r, zero_bit, {PAGE_SHIFT{1'b0}}};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_WORD) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_INIT:  state_nxt = ST_INIT;
            MODE_ALLOC: state_nxt = ST_SCAN;
            MODE_FREE:  state_nxt = free_in_range ? ST_FREE_RD : ST_FINISH;
            MODE_RSVD:  state_nxt = ST_FINISH;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_INIT: begin
        if (addr_r == LAST_WORD) state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (chk_vld_r && (!word_full || chk_addr_r == LAST_WORD)) state_nxt = ST_FINISH;
      end
      ST_FREE_RD: state_nxt = ST_FREE_WR;
      ST_FREE_WR: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    addr_nxt      = addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_vld_nxt   = 1'b0;
    bit_nxt       = bit_r;
    res_frame_nxt = res_frame_r;
    res_none_nxt  = res_none_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = WORD_FULL;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        addr_nxt = (addr_r == LAST_WORD) ? '0 : addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          res_frame_nxt = '0;
          res_none_nxt  = 1'b0;
          addr_nxt      = (in_mode == MODE_FREE) ? AW'(free_frame >> 3) : '0;
          bit_nxt       = free_frame[2:0];
        end
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_word;
        addr_nxt  = (addr_r == LAST_WORD) ? '0 : addr_r + 1'b1;
      end
      ST_SCAN: begin
        // one read issued per cycle; its data checked in the next cycle
        ram_re       = 1'b1;
        chk_addr_nxt = addr_r;
        chk_vld_nxt  = 1'b1;
        addr_nxt     = (addr_r == LAST_WORD) ? addr_r : addr_r + 1'b1;
        if (chk_vld_r) begin
          if (!word_full) begin
            ram_we        = 1'b1;
            ram_waddr     = chk_addr_r;
            ram_wdata     = ram_rdata | (WORD_W'(1) << zero_bit);
            res_frame_nxt = ADDR_W'(hit_byte_addr);
            chk_vld_nxt   = 1'b0;
          end else if (chk_addr_r == LAST_WORD) begin
            res_none_nxt  = 1'b1;
            chk_vld_nxt   = 1'b0;
          end
        end
      end
      ST_FREE_RD: begin
        ram_re = 1'b1;
      end
      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_r);
      end
      ST_FINISH: begin
        addr_nxt = '0;
      end
      default: begin
        addr_nxt = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      usable_kib_r <= USABLE_KIB_RST;
      reserved_r   <= RESERVED_RST;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_USABLE_KIB: usable_kib_r <= cfg_wdata;
          CFG_RESERVED:   reserved_r   <= cfg_wdata[RSV_W-1:0];
          default:        usable_kib_r <= usable_kib_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r  <= chk_addr_nxt;
    bit_r       <= bit_nxt;
    res_frame_r <= res_frame_nxt;
    res_none_r  <= res_none_nxt;
    if (out_load) begin
      out_frame_r <= res_frame_r;
      out_none_r  <= res_none_r;
    end
  end

endmodule

@@ verif/frame_alloc_monitor.sv @@
// Monitor for the frame allocator: predicts each result transaction and compares it.
module frame_alloc_monitor #(
  parameter int MAX_PAGES = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pfba_in_if                              in_ch,
  pfba_out_if                             out_ch,
  input  logic                            cfg_wen,
  input  logic [0:0]                      cfg_addr,
  input  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfba_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + 7) / 8;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    logic              none_free;
  } frame_result_t;

  logic [WORD_W-1:0] used_words [MAP_WORDS];
  logic [KIB_W-1:0]  mem_kib;
  logic [RSV_W-1:0]  rsv_frames;
  frame_result_t     frame_q [$];

  function automatic void rebuild_map();
    int unsigned lim;
    int unsigned rsv;
    // KiB to frames: 1024 bytes per KiB, 4 KiB per frame
    lim = 32'(mem_kib) >> (PAGE_SHIFT - 10);
    if (lim > MAX_PAGES) lim = MAX_PAGES;
    lim = (lim / 8) * 8;
    for (int w = 0; w < MAP_WORDS; w++) begin
      used_words[w] = (w * 8 < lim) ? '0 : WORD_FULL;
    end
    rsv = 32'(rsv_frames);
    if (rsv > MAX_PAGES) rsv = MAX_PAGES;
    for (int unsigned f = 0; f < rsv; f++) begin
      used_words[f / 8][f % 8] = 1'b1;
    end
  endfunction

  function automatic frame_result_t grab_lowest_frame();
    frame_result_t r;
    int unsigned f;
    r.frame_addr = '0;
    r.none_free  = 1'b1;
    for (int w = 0; w < MAP_WORDS; w++) begin
      if (used_words[w] != WORD_FULL) begin
        for (int b = 0; b < 8; b++) begin
          f = w * 8 + b;
          if (f < MAX_PAGES && !used_words[w][b]) begin
            used_words[w][b] = 1'b1;
            r.frame_addr = ADDR_W'(longint'(f) << PAGE_SHIFT);
            r.none_free  = 1'b0;
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic frame_result_t predict_request(mode_t m, logic [ADDR_W-1:0] a);
    frame_result_t r;
    int unsigned f;
    r.frame_addr = '0;
    r.none_free  = 1'b0;
    case (m)
      MODE_INIT: begin
        rebuild_map();
      end
      MODE_ALLOC: begin
        r = grab_lowest_frame();
      end
      MODE_FREE: begin
        f = 32'(a >> PAGE_SHIFT);
        if (f < MAX_PAGES) used_words[f / 8][f % 8] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_n) begin
      foreach (used_words[w]) used_words[w] = WORD_FULL;
      mem_kib    = USABLE_KIB_RST;
      rsv_frames = RESERVED_RST;
      frame_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_USABLE_KIB: mem_kib    = cfg_wdata[KIB_W-1:0];
          CFG_RESERVED:   rsv_frames = cfg_wdata[RSV_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.frame_addr = out_ch.frame_addr;
        got.none_free  = out_ch.none_free;
        if (frame_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with nothing expected: frame_addr %h none_free %b",
                   $time, got.frame_addr, got.none_free);
        end else begin
          want = frame_q.pop_front();
          if (got.frame_addr !== want.frame_addr) begin
            fail_count++;
            $display("%0t: frame_addr expected %h actual %h",
                     $time, want.frame_addr, got.frame_addr);
          end
          if (got.none_free !== want.none_free) begin
            fail_count++;
            $display("%0t: none_free expected %b actual %b",
                     $time, want.none_free, got.none_free);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_q.push_back(predict_request(mode_t'(in_ch.mode), in_ch.phys_addr));
      end
    end
    pending_count = frame_q.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the frame allocator testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfba_pkg::*;

  localparam int MAP_FRAMES       = 65536;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 16;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [0:0]            cfg_addr = CFG_USABLE_KIB;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending_count;
  bit                    idle_on = 1'b1;
  bit                    hold_req = 1'b0;
  int                    inits_left = 8;
  int unsigned           cycle_count = 0;

  pfba_in_if  req_ch ();
  pfba_out_if res_ch ();

  page_frame_bitmap_allocator_unit #(.MAX_PAGES(MAP_FRAMES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (req_ch),
    .out_if   (res_ch),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  frame_alloc_monitor #(.MAX_PAGES(MAP_FRAMES)) alloc_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (req_ch),
    .out_ch       (res_ch),
    .cfg_wen      (cfg_wen),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= m;
    req_ch.phys_addr <= a;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // drop valid and wait for every outstanding result, block left idle
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int n_items);
    int unsigned           rsv;
    int unsigned           kib;
    int unsigned           lo;
    int unsigned           r;
    int unsigned           fr;
    logic [CFG_DATA_W-1:0] rsv_word;
    rsv = $urandom_range(0, 2048);
    // keep over a thousand frames free so allocations never run dry
    if ($urandom_range(0, 3) == 0) kib = $urandom_range(262144, 524287);
    else kib = $urandom_range((rsv + 1024) * 4, 262143);
    rsv_word = CFG_DATA_W'(rsv);
    rsv_word[CFG_DATA_W-1:RSV_W] = (CFG_DATA_W-RSV_W)'($urandom_range(0, 3));
    write_reg(CFG_USABLE_KIB, CFG_DATA_W'(kib));
    write_reg(CFG_RESERVED, rsv_word);
    send_req(MODE_INIT, ADDR_W'($urandom));
    lo = (rsv > 64) ? rsv - 64 : 0;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        send_req(MODE_ALLOC, ADDR_W'($urandom));
      end else if (r < 88) begin
        fr = $urandom_range(lo, rsv + 512);
        send_req(MODE_FREE, ADDR_W'((fr << PAGE_SHIFT) | $urandom_range(0, 4095)));
      end else if (r < 95) begin
        send_req(MODE_FREE, ADDR_W'($urandom));
      end else if (r < 98) begin
        send_req(MODE_RSVD, ADDR_W'($urandom));
      end else if (inits_left > 0) begin
        inits_left--;
        send_req(MODE_INIT, ADDR_W'($urandom));
      end else begin
        send_req(MODE_ALLOC, ADDR_W'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_INIT;
    req_ch.phys_addr = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults; map is all used until the first init
    send_req(MODE_ALLOC, '0);
    send_req(MODE_RSVD, 28'hFFFFFFF);
    send_req(MODE_FREE, 28'hFFFFFFF);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_INIT, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 28'h0400ABC);
    send_req(MODE_FREE, 28'h0400ABC);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, '0);
    send_req(MODE_ALLOC, '0);
    settle();

    // no memory at all
    write_reg(CFG_USABLE_KIB, '0);
    write_reg(CFG_RESERVED, '0);
    send_req(MODE_INIT, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 28'h0000FFF);
    send_req(MODE_ALLOC, '0);
    settle();

    // both registers past the map size, so both saturate
    write_reg(CFG_USABLE_KIB, '1);
    write_reg(CFG_RESERVED, '1);
    send_req(MODE_INIT, 28'hFFFFFFF);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 28'h0005123);
    send_req(MODE_ALLOC, '0);
    settle();

    // 11 frames of memory round down to 8, of which 5 are reserved
    write_reg(CFG_USABLE_KIB, CFG_DATA_W'(44));
    write_reg(CFG_RESERVED, CFG_DATA_W'(5));
    send_req(MODE_INIT, '0);
    repeat (4) send_req(MODE_ALLOC, '0);
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 1) hold_req = 1'b1;
      if (p == 5) idle_on = 1'b0;
      run_random_phase(72);
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pfba_pkg.sv
rtl/pfba_if.sv
rtl/pfba_ram.sv
rtl/page_frame_bitmap_allocator_unit.sv
verif/frame_alloc_monitor.sv
verif/testbench.sv
